// File: hdl/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define RCFD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Property checked on every rising clock edge, reset included.
`define RCFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: hdl/rcfd_pkg.sv
// Types, constants and helper functions of the receiver frame decoder.
package rcfd_pkg;

  localparam int SWITCH_HISTORY_DEPTH_DEF = 16;
  localparam int FRAME_LENGTH_DEF         = 18;
  localparam int STORE_DEPTH              = 16;

  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_STABLE_FRAMES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD_FRAMES   = 1'd1;
  localparam logic [CFG_W-1:0]     STABLE_FRAMES_RST = 8'd40;
  localparam logic [CFG_W-1:0]     HOLD_FRAMES_RST   = 8'd40;

  localparam logic [1:0] SW_UP     = 2'd1;
  localparam logic [1:0] SW_DOWN   = 2'd3;
  localparam logic [1:0] MODE_UP   = 2'd0;
  localparam logic [1:0] MODE_DOWN = 2'd1;
  localparam logic [1:0] MODE_MID  = 2'd2;

  localparam int OUT_TDATA_W = 144;

  typedef struct packed {
    logic [CFG_W-1:0] stable_frames;
    logic [CFG_W-1:0] hold_frames;
  } cfg_t;

  typedef struct packed {
    logic [STORE_DEPTH-1:0][7:0] bytes;
    logic                        button;
  } frame_t;

  // Packed so that the last field lands in the lowest bits.
  typedef struct packed {
    logic [6:0]         pad;
    logic               test_mode;
    logic [1:0]         switch_held;
    logic [5:0]         switch_history;
    logic [1:0]         left_mode;
    logic [1:0]         right_mode;
    logic [15:0]        keys;
    logic [15:0]        mouse_buttons;
    logic signed [15:0] mouse_z;
    logic signed [15:0] mouse_y;
    logic signed [15:0] mouse_x;
    logic [43:0]        sticks;
  } result_t;

  function automatic logic [1:0] mode_of(input logic [1:0] s);
    logic [1:0] m;
    case (s)
      SW_UP:   m = MODE_UP;
      SW_DOWN: m = MODE_DOWN;
      default: m = MODE_MID;
    endcase
    return m;
  endfunction

endpackage

// File: hdl/rc_receiver_frame_decoder.sv
// Top level of the remote-control receiver frame decoder.
// Takes one receiver byte per transfer and gives one decoded result after the last byte
// of each FRAME_LENGTH-byte frame; a byte with frame_start set restarts the frame. The
// block sustains one byte transfer every cycle unless the frame register holds a frame that
// the decode stage does not take. A result is offered once the frame's last byte has passed
// the frame register of the capture stage and the result register of the decode stage;
// each stage holds one frame while stalled.
module rc_receiver_frame_decoder import rcfd_pkg::*; #(
  parameter int SWITCH_HISTORY_DEPTH = SWITCH_HISTORY_DEPTH_DEF,
  parameter int FRAME_LENGTH         = FRAME_LENGTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]       cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [7:0]             in_tdata,  // rx_byte
  input  logic [1:0]             in_tuser,  // frame_start, button_pressed
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // sticks, mouse_x, mouse_y, mouse_z, mouse_buttons, keys, right_mode, left_mode,
  // switch_history, switch_held, test_mode, zero fill
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  cfg_t    cfg_r;
  logic    frame_valid, frame_take;
  frame_t  frame;
  result_t result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stable_frames <= STABLE_FRAMES_RST;
      cfg_r.hold_frames   <= HOLD_FRAMES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_STABLE_FRAMES: cfg_r.stable_frames <= cfg_wdata;
        CFG_HOLD_FRAMES:   cfg_r.hold_frames   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  rcfd_capture #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_capture (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_tvalid),
    .in_ready      (in_tready),
    .rx_byte       (in_tdata),
    .frame_start   (in_tuser[0]),
    .button_pressed(in_tuser[1]),
    .frame_valid   (frame_valid),
    .frame_take    (frame_take),
    .frame         (frame)
  );

  rcfd_decode #(
    .SWITCH_HISTORY_DEPTH(SWITCH_HISTORY_DEPTH)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .frame_valid(frame_valid),
    .frame_take (frame_take),
    .frame      (frame),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .result     (result)
  );

  assign out_tdata = result;

endmodule

// File: hdl/rcfd_capture.sv
// Byte capture stage: byte position, frame store and the frame register.
module rcfd_capture import rcfd_pkg::*; #(
  parameter int FRAME_LENGTH = FRAME_LENGTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  input  logic       button_pressed,
  output logic       frame_valid,
  input  logic       frame_take,
  output frame_t     frame
);

  localparam int POS_W = $clog2(FRAME_LENGTH);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_LENGTH - 1);

  logic [POS_W-1:0] pos_r, pos_nxt, pos_eff;
  logic [7:0]       store_r [STORE_DEPTH];
  logic             fv_r, fv_nxt;
  frame_t           frame_r, frame_nxt;
  logic             accept, last;

  assign in_ready    = !fv_r || frame_take;
  assign accept      = in_valid && in_ready;
  assign pos_eff     = frame_start ? '0 : pos_r;
  assign last        = (pos_eff == LAST_POS);
  assign frame_valid = fv_r;
  assign frame       = frame_r;

  always_comb begin
    pos_nxt = last ? '0 : pos_eff + 1'b1;
    fv_nxt  = fv_r;
    if (accept && last) begin
      fv_nxt = 1'b1;
    end else if (frame_take) begin
      fv_nxt = 1'b0;
    end
    // The last byte itself is part of the frame when it falls inside the store.
    for (int k = 0; k < STORE_DEPTH; k++) begin
      frame_nxt.bytes[k] = (int'(pos_eff) == k) ? rx_byte : store_r[k];
    end
    frame_nxt.button = button_pressed;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
      fv_r  <= 1'b0;
    end else begin
      fv_r <= fv_nxt;
      if (accept) begin
        pos_r <= pos_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (int'(pos_eff) < STORE_DEPTH)) begin
      store_r[pos_eff[$clog2(STORE_DEPTH)-1:0]] <= rx_byte;
    end
    if (accept && last) begin
      frame_r <= frame_nxt;
    end
  end

endmodule

// File: hdl/rcfd_decode.sv
// Frame decode stage: field extraction, switch history, hold counters, result register.
module rcfd_decode import rcfd_pkg::*; #(
  parameter int SWITCH_HISTORY_DEPTH = SWITCH_HISTORY_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cfg_t    cfg,
  input  logic    frame_valid,
  output logic    frame_take,
  input  frame_t  frame,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t result
);

  localparam int SR_N = SWITCH_HISTORY_DEPTH - 1;

  logic [1:0] sr_r [SR_N];
  logic       first_r;
  logic [7:0] eq_cnt_r, eq_cnt_nxt;
  logic [1:0] held_r, held_nxt;
  logic [7:0] btn_cnt_r, btn_cnt_nxt;
  logic       test_r, test_nxt;
  logic       ov_r;
  result_t    res_r, res_nxt;
  logic [1:0] s1, s2, prev_v;

  assign frame_take = frame_valid && (!ov_r || out_ready);
  assign out_valid  = ov_r;
  assign result     = res_r;

  always_comb begin
    s1     = frame.bytes[5][7:6];
    s2     = frame.bytes[5][5:4];
    prev_v = first_r ? s1 : sr_r[0];

    if (prev_v == s1) begin
      eq_cnt_nxt = (eq_cnt_r == 8'hFF) ? eq_cnt_r : eq_cnt_r + 8'd1;
    end else begin
      eq_cnt_nxt = 8'd0;
    end
    held_nxt = (eq_cnt_nxt >= cfg.stable_frames) ? s1 : held_r;

    btn_cnt_nxt = frame.button ? btn_cnt_r + 8'd1 : 8'd0;
    test_nxt    = (frame.button && (btn_cnt_nxt == cfg.hold_frames)) ? !test_r : test_r;

    res_nxt.pad            = '0;
    res_nxt.test_mode      = test_nxt;
    res_nxt.switch_held    = held_nxt;
    res_nxt.switch_history = {sr_r[SR_N-1], prev_v, s1};
    res_nxt.left_mode      = mode_of(s1);
    res_nxt.right_mode     = mode_of(s2);
    res_nxt.keys           = {frame.bytes[15], frame.bytes[14]};
    res_nxt.mouse_buttons  = {frame.bytes[13], frame.bytes[12]};
    res_nxt.mouse_z        = {frame.bytes[11], frame.bytes[10]};
    res_nxt.mouse_y        = {frame.bytes[9], frame.bytes[8]};
    res_nxt.mouse_x        = {frame.bytes[7], frame.bytes[6]};
    res_nxt.sticks         = {frame.bytes[5][3:0], frame.bytes[4][7:1],
                              frame.bytes[4][0], frame.bytes[3], frame.bytes[2][7:6],
                              frame.bytes[2][5:0], frame.bytes[1][7:3],
                              frame.bytes[1][2:0], frame.bytes[0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SR_N; i++) begin
        sr_r[i] <= 2'd0;
      end
      first_r   <= 1'b1;
      eq_cnt_r  <= 8'd0;
      held_r    <= 2'd0;
      btn_cnt_r <= 8'd0;
      test_r    <= 1'b0;
      ov_r      <= 1'b0;
    end else begin
      if (frame_take) begin
        sr_r[0] <= s1;
        for (int i = 1; i < SR_N; i++) begin
          sr_r[i] <= sr_r[i-1];
        end
        first_r   <= 1'b0;
        eq_cnt_r  <= eq_cnt_nxt;
        held_r    <= held_nxt;
        btn_cnt_r <= btn_cnt_nxt;
        test_r    <= test_nxt;
        ov_r      <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      res_r <= res_nxt;
    end
  end

endmodule

// File: hdl/rcfd_checker.sv
// Port-level checker of the receiver frame decoder and its bind statement.
`include "assert_macros.svh"

module rcfd_checker import rcfd_pkg::*; (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  `RCFD_ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_tvalid, "result valid after reset")
  `RCFD_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid, "result dropped")
  `RCFD_ASSERT(a_out_stable, clk, rst_n, out_tvalid && !out_tready |=> $stable(out_tdata), "result changed while stalled")
  `RCFD_ASSERT(a_ready_when_empty, clk, rst_n, !out_tvalid |-> in_tready, "input stalled with empty result register")

endmodule

bind rc_receiver_frame_decoder rcfd_checker u_rcfd_checker (.*);
